### rtl/core/nfcr_pkg.sv
// Package for the normal frame receiver core: receive phase encoding,
// frame status codes, register indexes and fixed frame byte values.
// No dependencies.
`timescale 1ns / 1ps

package nfcr_pkg;

   typedef enum logic [3:0] {
      PH_PRE0 = 4'd0,
      PH_PRE1 = 4'd1,
      PH_PRE2 = 4'd2,
      PH_LEN  = 4'd3,
      PH_LCS  = 4'd4,
      PH_TFI  = 4'd5,
      PH_CODE = 4'd6,
      PH_DATA = 4'd7,
      PH_DCS  = 4'd8,
      PH_POST = 4'd9,
      PH_SKIP = 4'd10,
      PH_BAD1 = 4'd11,
      PH_BAD2 = 4'd12,
      PH_BAD3 = 4'd13,
      PH_BAD4 = 4'd14
   } phase_type;

   typedef enum logic [3:0] {
      ST_BUSY     = 4'd0,
      ST_OK       = 4'd1,
      ST_PREAMBLE = 4'd2,
      ST_APPERR   = 4'd3,
      ST_EXTENDED = 4'd4,
      ST_LCS      = 4'd5,
      ST_SHORT    = 4'd6,
      ST_TOOBIG   = 4'd7,
      ST_TFI      = 4'd8,
      ST_CODE     = 4'd9,
      ST_DCS      = 4'd10,
      ST_POST     = 4'd11
   } status_type;

   typedef enum logic {
      CSR_SENT_COMMAND     = 1'b0,
      CSR_PAYLOAD_CAPACITY = 1'b1
   } csr_index_type;

   localparam logic [7:0] PRE_ZERO      = 8'h00;
   localparam logic [7:0] PRE_START     = 8'hFF;
   localparam logic [7:0] TFI_VALUE     = 8'hD5;
   localparam logic [7:0] APPERR_LEN    = 8'h01;
   localparam logic [7:0] EXT_MARK      = 8'hFF;
   localparam logic [7:0] POSTAMBLE     = 8'h00;
   localparam logic [7:0] MIN_LEN       = 8'd2;
   localparam logic [8:0] LCS_SUM       = 9'd256;
   localparam logic [1:0] APPERR_SKIP   = 2'd2;
   localparam logic [7:0] CAPACITY_INIT = 8'd253;

endpackage

### rtl/core/nfc_normal_frame_receiver_core.sv
// Top level of the normal frame receiver: checks a received byte stream
// against the normal information frame layout. Depends on nfcr_pkg.
`timescale 1ns / 1ps

// Each accepted request is one received byte and yields exactly one response
// in the next cycle: a payload byte flagged in rsp_tuser, or a busy marker, or at
// the end of a frame (rsp_tlast high) a status code with the payload length on
// success. The block takes one byte per clock: the frame check is a short
// compare/8-bit add step feeding a single response register, and a new request
// is taken whenever that register is empty or being read out in the same cycle.
// A bad preamble still consumes five header bytes; an application error frame
// absorbs three more bytes before its status. Write the csr registers only while
// no response is outstanding.
module nfc_normal_frame_receiver_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] payload_byte, [11:8] frame_status,
                                     // [19:12] frame_length, [23:20] zero
   output logic        rsp_tuser,    // payload_valid
   output logic        rsp_tlast,    // frame_end
   // configuration
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);

   nfcr_pkg::phase_type  phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] csum_ff, csum_in;
   logic [1:0] skip_ff, skip_in;
   logic [7:0] sent_command_ff;
   logic [7:0] capacity_ff;

   logic                 rsp_valid_ff;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_pvalid_ff, rsp_pvalid_in;
   logic                 rsp_end_ff, rsp_end_in;
   nfcr_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [7:0]           rsp_length_ff, rsp_length_in;

   logic       accept;
   logic [7:0] rx;
   logic [8:0] expect_code;
   logic [8:0] lcs_sum;
   logic [7:0] payload_len;
   logic [7:0] csum_add;

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign rx          = req_tdata;
   assign expect_code = {1'b0, sent_command_ff} + 9'd1;
   assign lcs_sum     = {1'b0, length_ff} + {1'b0, rx};
   assign payload_len = length_ff - nfcr_pkg::MIN_LEN;
   assign csum_add    = csum_ff + rx;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      left_in   = left_ff;
      csum_in   = csum_ff;
      skip_in   = skip_ff;
      case (phase_ff)
         nfcr_pkg::PH_PRE0: begin
            phase_in = (rx == nfcr_pkg::PRE_ZERO) ? nfcr_pkg::PH_PRE1 : nfcr_pkg::PH_BAD1;
         end
         nfcr_pkg::PH_PRE1: begin
            phase_in = (rx == nfcr_pkg::PRE_ZERO) ? nfcr_pkg::PH_PRE2 : nfcr_pkg::PH_BAD2;
         end
         nfcr_pkg::PH_PRE2: begin
            phase_in = (rx == nfcr_pkg::PRE_START) ? nfcr_pkg::PH_LEN : nfcr_pkg::PH_BAD3;
         end
         nfcr_pkg::PH_BAD1: phase_in = nfcr_pkg::PH_BAD2;
         nfcr_pkg::PH_BAD2: phase_in = nfcr_pkg::PH_BAD3;
         nfcr_pkg::PH_BAD3: begin
            length_in = rx;
            phase_in  = nfcr_pkg::PH_BAD4;
         end
         nfcr_pkg::PH_BAD4: phase_in = nfcr_pkg::PH_PRE0;
         nfcr_pkg::PH_LEN: begin
            length_in = rx;
            phase_in  = nfcr_pkg::PH_LCS;
         end
         nfcr_pkg::PH_LCS: begin
            if (length_ff == nfcr_pkg::APPERR_LEN && rx == nfcr_pkg::EXT_MARK) begin
               skip_in  = nfcr_pkg::APPERR_SKIP;
               phase_in = nfcr_pkg::PH_SKIP;
            end else if (length_ff == nfcr_pkg::EXT_MARK && rx == nfcr_pkg::EXT_MARK) begin
               phase_in = nfcr_pkg::PH_PRE0;
            end else if (lcs_sum != nfcr_pkg::LCS_SUM) begin
               phase_in = nfcr_pkg::PH_PRE0;
            end else if (length_ff < nfcr_pkg::MIN_LEN) begin
               phase_in = nfcr_pkg::PH_PRE0;
            end else if (payload_len > capacity_ff) begin
               phase_in = nfcr_pkg::PH_PRE0;
            end else begin
               phase_in = nfcr_pkg::PH_TFI;
            end
         end
         nfcr_pkg::PH_SKIP: begin
            if (skip_ff == 2'd0) begin
               phase_in = nfcr_pkg::PH_PRE0;
            end else begin
               skip_in = skip_ff - 2'd1;
            end
         end
         nfcr_pkg::PH_TFI: begin
            csum_in  = rx;
            phase_in = nfcr_pkg::PH_CODE;
         end
         nfcr_pkg::PH_CODE: begin
            if (csum_ff != nfcr_pkg::TFI_VALUE || {1'b0, rx} != expect_code) begin
               phase_in = nfcr_pkg::PH_PRE0;
            end else begin
               csum_in  = nfcr_pkg::TFI_VALUE + rx;
               left_in  = payload_len;
               phase_in = (payload_len == 8'd0) ? nfcr_pkg::PH_DCS : nfcr_pkg::PH_DATA;
            end
         end
         nfcr_pkg::PH_DATA: begin
            csum_in = csum_add;
            left_in = left_ff - 8'd1;
            if (left_ff == 8'd1) begin
               phase_in = nfcr_pkg::PH_DCS;
            end
         end
         nfcr_pkg::PH_DCS: begin
            csum_in  = csum_add;
            phase_in = nfcr_pkg::PH_POST;
         end
         nfcr_pkg::PH_POST: phase_in = nfcr_pkg::PH_PRE0;
         default: phase_in = nfcr_pkg::PH_PRE0;
      endcase
   end

   // response for the current request
   always_comb begin
      rsp_byte_in   = 8'd0;
      rsp_pvalid_in = 1'b0;
      rsp_end_in    = 1'b0;
      rsp_status_in = nfcr_pkg::ST_BUSY;
      rsp_length_in = 8'd0;
      case (phase_ff)
         nfcr_pkg::PH_BAD4: begin
            rsp_end_in    = 1'b1;
            rsp_status_in = nfcr_pkg::ST_PREAMBLE;
         end
         nfcr_pkg::PH_LCS: begin
            if (length_ff == nfcr_pkg::APPERR_LEN && rx == nfcr_pkg::EXT_MARK) begin
               rsp_end_in = 1'b0;
            end else if (length_ff == nfcr_pkg::EXT_MARK && rx == nfcr_pkg::EXT_MARK) begin
               rsp_end_in    = 1'b1;
               rsp_status_in = nfcr_pkg::ST_EXTENDED;
            end else if (lcs_sum != nfcr_pkg::LCS_SUM) begin
               rsp_end_in    = 1'b1;
               rsp_status_in = nfcr_pkg::ST_LCS;
            end else if (length_ff < nfcr_pkg::MIN_LEN) begin
               rsp_end_in    = 1'b1;
               rsp_status_in = nfcr_pkg::ST_SHORT;
            end else if (payload_len > capacity_ff) begin
               rsp_end_in    = 1'b1;
               rsp_status_in = nfcr_pkg::ST_TOOBIG;
            end
         end
         nfcr_pkg::PH_SKIP: begin
            if (skip_ff == 2'd0) begin
               rsp_end_in    = 1'b1;
               rsp_status_in = nfcr_pkg::ST_APPERR;
            end
         end
         nfcr_pkg::PH_CODE: begin
            if (csum_ff != nfcr_pkg::TFI_VALUE) begin
               rsp_end_in    = 1'b1;
               rsp_status_in = nfcr_pkg::ST_TFI;
            end else if ({1'b0, rx} != expect_code) begin
               rsp_end_in    = 1'b1;
               rsp_status_in = nfcr_pkg::ST_CODE;
            end
         end
         nfcr_pkg::PH_DATA: begin
            rsp_byte_in   = rx;
            rsp_pvalid_in = 1'b1;
         end
         nfcr_pkg::PH_POST: begin
            rsp_end_in = 1'b1;
            if (csum_ff != 8'd0) begin
               rsp_status_in = nfcr_pkg::ST_DCS;
            end else if (rx != nfcr_pkg::POSTAMBLE) begin
               rsp_status_in = nfcr_pkg::ST_POST;
            end else begin
               rsp_status_in = nfcr_pkg::ST_OK;
               rsp_length_in = payload_len;
            end
         end
         default: rsp_end_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= nfcr_pkg::PH_PRE0;
         length_ff       <= 8'd0;
         left_ff         <= 8'd0;
         csum_ff         <= 8'd0;
         skip_ff         <= 2'd0;
         sent_command_ff <= 8'd0;
         capacity_ff     <= nfcr_pkg::CAPACITY_INIT;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            length_ff <= length_in;
            left_ff   <= left_in;
            csum_ff   <= csum_in;
            skip_ff   <= skip_in;
         end
         if (csr_we) begin
            if (csr_addr == nfcr_pkg::CSR_SENT_COMMAND) begin
               sent_command_ff <= csr_wdata;
            end else begin
               capacity_ff <= csr_wdata;
            end
         end
         // hold the response until taken, refill on a new request
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_pvalid_ff <= rsp_pvalid_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_status_ff <= rsp_status_in;
         rsp_length_ff <= rsp_length_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_length_ff, rsp_status_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_pvalid_ff;
   assign rsp_tlast  = rsp_end_ff;

endmodule

### tb/tb.sv
// Self-checking bench for nfc_normal_frame_receiver_core: byte-level frame
// checker with its own deframer, directed table, then random frames.
// Depends on nfcr_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;

   // one response as seen on the rsp channel
   typedef struct packed {
      logic [7:0]           data;
      logic                 valid;
      logic                 last;
      nfcr_pkg::status_type status;
      logic [7:0]           length;
   } result_type;

   typedef struct packed {
      logic [7:0] rx;
      logic       lit;
      result_type want;
   } byte_row_type;

   typedef enum {
      FK_GOOD, FK_CORRUPT, FK_APPERR, FK_EXTENDED, FK_SHORT, FK_TOOBIG, FK_NOISE
   } frame_kind_type;

   localparam result_type BUSY_OUT     = '{8'h00, 1'b0, 1'b0, nfcr_pkg::ST_BUSY, 8'd0};
   localparam result_type PAY_FF_OUT   = '{8'hFF, 1'b1, 1'b0, nfcr_pkg::ST_BUSY, 8'd0};
   localparam result_type OK_ONE_OUT   = '{8'h00, 1'b0, 1'b1, nfcr_pkg::ST_OK, 8'd1};
   localparam result_type APPERR_OUT   = '{8'h00, 1'b0, 1'b1, nfcr_pkg::ST_APPERR, 8'd0};
   localparam result_type PREAMBLE_OUT = '{8'h00, 1'b0, 1'b1, nfcr_pkg::ST_PREAMBLE,
                                          8'd0};
   localparam result_type EXTEND_OUT   = '{8'h00, 1'b0, 1'b1, nfcr_pkg::ST_EXTENDED,
                                          8'd0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_addr = nfcr_pkg::CSR_SENT_COMMAND;
   logic [7:0]  csr_wdata = 8'h00;

   nfc_normal_frame_receiver_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // deframer state and its copy of the registers
   nfcr_pkg::phase_type dfr_phase = nfcr_pkg::PH_PRE0;
   logic [7:0] dfr_len = 8'd0;
   logic [7:0] dfr_left = 8'd0;
   logic [7:0] dfr_sum = 8'd0;
   logic [1:0] dfr_skip = 2'd0;
   logic [7:0] dfr_command = 8'd0;
   logic [7:0] dfr_capacity = nfcr_pkg::CAPACITY_INIT;

   result_type   deframer_out_q[$];
   byte_row_type dir_rows[$];

   int errors = 0;
   int sent_bytes = 0;
   int frames_closed = 0;
   int settings_used = 1;
   int cycle_count = 0;
   int send_idle = 0;
   int rcv_stall = 0;
   int hold_left = 0;
   int hold_asks = 0;
   int hold_served = 0;

   function automatic void close_frame(inout result_type r, input nfcr_pkg::status_type s);
      r.last = 1'b1;
      r.status = s;
      dfr_phase = nfcr_pkg::PH_PRE0;
   endfunction

   function automatic result_type deframe_byte(input logic [7:0] b);
      result_type r;
      logic [8:0] want_code;
      r = BUSY_OUT;
      want_code = {1'b0, dfr_command} + 9'd1;
      case (dfr_phase)
         nfcr_pkg::PH_PRE0:
            dfr_phase = (b == nfcr_pkg::PRE_ZERO) ? nfcr_pkg::PH_PRE1 : nfcr_pkg::PH_BAD1;
         nfcr_pkg::PH_PRE1:
            dfr_phase = (b == nfcr_pkg::PRE_ZERO) ? nfcr_pkg::PH_PRE2 : nfcr_pkg::PH_BAD2;
         nfcr_pkg::PH_PRE2:
            dfr_phase = (b == nfcr_pkg::PRE_START) ? nfcr_pkg::PH_LEN : nfcr_pkg::PH_BAD3;
         nfcr_pkg::PH_BAD1: dfr_phase = nfcr_pkg::PH_BAD2;
         nfcr_pkg::PH_BAD2: dfr_phase = nfcr_pkg::PH_BAD3;
         nfcr_pkg::PH_BAD3: begin
            dfr_len = b;
            dfr_phase = nfcr_pkg::PH_BAD4;
         end
         nfcr_pkg::PH_BAD4: close_frame(r, nfcr_pkg::ST_PREAMBLE);
         nfcr_pkg::PH_LEN: begin
            dfr_len = b;
            dfr_phase = nfcr_pkg::PH_LCS;
         end
         nfcr_pkg::PH_LCS: begin
            if (dfr_len == nfcr_pkg::APPERR_LEN && b == 8'hFF) begin
               dfr_skip = nfcr_pkg::APPERR_SKIP;
               dfr_phase = nfcr_pkg::PH_SKIP;
            end else if (dfr_len == nfcr_pkg::EXT_MARK && b == nfcr_pkg::EXT_MARK)
               close_frame(r, nfcr_pkg::ST_EXTENDED);
            else if ({1'b0, dfr_len} + {1'b0, b} != nfcr_pkg::LCS_SUM)
               close_frame(r, nfcr_pkg::ST_LCS);
            else if (dfr_len < nfcr_pkg::MIN_LEN)
               close_frame(r, nfcr_pkg::ST_SHORT);
            else if (dfr_len - nfcr_pkg::MIN_LEN > dfr_capacity)
               close_frame(r, nfcr_pkg::ST_TOOBIG);
            else
               dfr_phase = nfcr_pkg::PH_TFI;
         end
         nfcr_pkg::PH_SKIP: begin
            if (dfr_skip == 2'd0)
               close_frame(r, nfcr_pkg::ST_APPERR);
            else
               dfr_skip = dfr_skip - 2'd1;
         end
         nfcr_pkg::PH_TFI: begin
            dfr_sum = b;
            dfr_phase = nfcr_pkg::PH_CODE;
         end
         nfcr_pkg::PH_CODE: begin
            if (dfr_sum != nfcr_pkg::TFI_VALUE)
               close_frame(r, nfcr_pkg::ST_TFI);
            else if ({1'b0, b} != want_code)
               close_frame(r, nfcr_pkg::ST_CODE);
            else begin
               dfr_sum = nfcr_pkg::TFI_VALUE + b;
               dfr_left = dfr_len - nfcr_pkg::MIN_LEN;
               dfr_phase = (dfr_left == 8'd0) ? nfcr_pkg::PH_DCS : nfcr_pkg::PH_DATA;
            end
         end
         nfcr_pkg::PH_DATA: begin
            r.data = b;
            r.valid = 1'b1;
            dfr_sum = dfr_sum + b;
            dfr_left = dfr_left - 8'd1;
            if (dfr_left == 8'd0)
               dfr_phase = nfcr_pkg::PH_DCS;
         end
         nfcr_pkg::PH_DCS: begin
            dfr_sum = dfr_sum + b;
            dfr_phase = nfcr_pkg::PH_POST;
         end
         nfcr_pkg::PH_POST: begin
            if (dfr_sum != 8'd0)
               close_frame(r, nfcr_pkg::ST_DCS);
            else if (b != nfcr_pkg::POSTAMBLE)
               close_frame(r, nfcr_pkg::ST_POST);
            else begin
               close_frame(r, nfcr_pkg::ST_OK);
               r.length = dfr_len - nfcr_pkg::MIN_LEN;
            end
         end
         default: dfr_phase = nfcr_pkg::PH_PRE0;
      endcase
      return r;
   endfunction

   // offer one request byte, record what it must produce once accepted
   task automatic offer_byte(input logic [7:0] b, input logic use_lit,
                             input result_type lit, output logic ended);
      result_type r;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      r = deframe_byte(b);
      deframer_out_q.push_back(use_lit ? lit : r);
      sent_bytes++;
      ended = r.last;
   endtask

   task automatic drain_responses;
      req_tvalid <= 1'b0;
      while (deframer_out_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input nfcr_pkg::csr_index_type idx, input logic [7:0] v);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == nfcr_pkg::CSR_SENT_COMMAND)
         dfr_command = v;
      else
         dfr_capacity = v;
      @(posedge clock);
   endtask

   task automatic send_frame(input frame_kind_type kind, input int paylen);
      logic [7:0] fb[$];
      logic [7:0] len, sum, code, x;
      int spot;
      logic ended;
      fb = '{nfcr_pkg::PRE_ZERO, nfcr_pkg::PRE_ZERO, nfcr_pkg::PRE_START};
      code = dfr_command + 8'd1;
      if (kind == FK_TOOBIG && dfr_capacity > 8'd252)
         kind = FK_GOOD;
      case (kind)
         FK_GOOD, FK_CORRUPT: begin
            len = 8'(paylen + 2);
            fb.push_back(len);
            fb.push_back(-len);
            fb.push_back(nfcr_pkg::TFI_VALUE);
            fb.push_back(code);
            sum = nfcr_pkg::TFI_VALUE + code;
            for (int i = 0; i < paylen; i++) begin
               x = 8'($urandom);
               fb.push_back(x);
               sum = sum + x;
            end
            fb.push_back(-sum);
            fb.push_back(nfcr_pkg::POSTAMBLE);
            if (kind == FK_CORRUPT) begin
               spot = $urandom_range(fb.size() - 1);
               fb[spot] = fb[spot] ^ 8'($urandom_range(1, 255));
            end
         end
         FK_APPERR: begin
            fb.push_back(nfcr_pkg::APPERR_LEN);
            fb.push_back(8'hFF);
            repeat (3) fb.push_back(8'($urandom));
         end
         FK_EXTENDED: begin
            fb.push_back(nfcr_pkg::EXT_MARK);
            fb.push_back(nfcr_pkg::EXT_MARK);
         end
         FK_SHORT: begin
            fb.push_back(8'h00);
            fb.push_back(8'h00);
         end
         FK_TOOBIG: begin
            len = 8'($urandom_range(int'(dfr_capacity) + 3, 255));
            fb.push_back(len);
            fb.push_back(-len);
         end
         default: begin
            fb.delete();
            repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
         end
      endcase
      // stop at the frame end so the next frame starts aligned
      foreach (fb[i]) begin
         offer_byte(fb[i], 1'b0, BUSY_OUT, ended);
         if (ended && kind != FK_NOISE)
            break;
      end
   endtask

   // receiver side: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_asks != hold_served) begin
         hold_served <= hold_asks;
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else
         rsp_tready <= ($urandom_range(99) >= rcv_stall);
   end

   always @(posedge clock) begin
      result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], rsp_tuser, rsp_tlast,
                 nfcr_pkg::status_type'(rsp_tdata[11:8]), rsp_tdata[19:12]};
         if (got.last)
            frames_closed++;
         if (deframer_out_q.size() == 0) begin
            $display("%0t: unexpected response tdata %h tuser %b tlast %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            want = deframer_out_q.pop_front();
            if (got.data != want.data) begin
               $display("%0t: payload_byte expected %h got %h", $time, want.data, got.data);
               errors++;
            end
            if (got.valid != want.valid) begin
               $display("%0t: payload_valid expected %b got %b", $time, want.valid,
                        got.valid);
               errors++;
            end
            if (got.last != want.last) begin
               $display("%0t: frame_end expected %b got %b", $time, want.last, got.last);
               errors++;
            end
            if (got.status != want.status) begin
               $display("%0t: frame_status expected %0d got %0d", $time, want.status,
                        got.status);
               errors++;
            end
            if (got.length != want.length) begin
               $display("%0t: frame_length expected %0d got %0d", $time, want.length,
                        got.length);
               errors++;
            end
            if (rsp_tdata[23:20] != 4'd0) begin
               $display("%0t: tdata pad expected 0 got %h", $time, rsp_tdata[23:20]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("nfc_normal_frame_receiver_core regression: fail");
         $finish;
      end
   end

   initial begin
      logic [7:0] cmd_set [6];
      logic [7:0] cap_set [6];
      int idle_set [4];
      int stall_set [4];
      int phase_goal, pick, plen;
      frame_kind_type kind;
      logic ended;

      cmd_set = '{8'h4A, 8'hFF, 8'h00, 8'hD4, 8'h00, 8'h00};
      cap_set = '{8'd253, 8'd1, 8'd0, 8'd253, 8'd253, 8'd253};
      idle_set = '{0, 86, 0, 35};
      stall_set = '{0, 0, 86, 35};

      // good frame with one FF payload byte, application error frame,
      // bad preamble, extended frame; default registers (command 00)
      dir_rows = '{
         '{8'h00, 1'b1, BUSY_OUT}, '{8'h00, 1'b0, BUSY_OUT}, '{8'hFF, 1'b0, BUSY_OUT},
         '{8'h03, 1'b0, BUSY_OUT}, '{8'hFD, 1'b0, BUSY_OUT}, '{8'hD5, 1'b0, BUSY_OUT},
         '{8'h01, 1'b0, BUSY_OUT}, '{8'hFF, 1'b1, PAY_FF_OUT}, '{8'h2B, 1'b0, BUSY_OUT},
         '{8'h00, 1'b1, OK_ONE_OUT},
         '{8'h00, 1'b0, BUSY_OUT}, '{8'h00, 1'b0, BUSY_OUT}, '{8'hFF, 1'b0, BUSY_OUT},
         '{8'h01, 1'b0, BUSY_OUT}, '{8'hFF, 1'b0, BUSY_OUT}, '{8'hA5, 1'b0, BUSY_OUT},
         '{8'h5A, 1'b0, BUSY_OUT}, '{8'h3C, 1'b1, APPERR_OUT},
         '{8'h7E, 1'b0, BUSY_OUT}, '{8'h00, 1'b0, BUSY_OUT}, '{8'hFF, 1'b0, BUSY_OUT},
         '{8'h03, 1'b0, BUSY_OUT}, '{8'hFD, 1'b1, PREAMBLE_OUT},
         '{8'h00, 1'b0, BUSY_OUT}, '{8'h00, 1'b0, BUSY_OUT}, '{8'hFF, 1'b0, BUSY_OUT},
         '{8'hFF, 1'b0, BUSY_OUT}, '{8'hFF, 1'b1, EXTEND_OUT}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         offer_byte(dir_rows[i].rx, dir_rows[i].lit, dir_rows[i].want, ended);

      for (int ph = 0; ph < 6; ph++) begin
         drain_responses();
         if (ph == 2 || ph == 5)
            write_csr(nfcr_pkg::CSR_SENT_COMMAND, 8'($urandom));
         else
            write_csr(nfcr_pkg::CSR_SENT_COMMAND, cmd_set[ph]);
         if (ph == 3 || ph == 5)
            write_csr(nfcr_pkg::CSR_PAYLOAD_CAPACITY, 8'($urandom_range(1, 253)));
         else
            write_csr(nfcr_pkg::CSR_PAYLOAD_CAPACITY, cap_set[ph]);
         settings_used++;
         send_idle = idle_set[ph % 4];
         rcv_stall = stall_set[ph % 4];
         if (ph == 0)
            send_frame(FK_GOOD, int'(dfr_capacity));
         // hold the receiver off while the sender keeps pushing
         if (ph == 4)
            hold_asks++;
         phase_goal = sent_bytes + 25;
         while (sent_bytes < phase_goal) begin
            pick = $urandom_range(99);
            plen = ($urandom_range(39) == 0) ? $urandom_range(40) : $urandom_range(6);
            if (plen > int'(dfr_capacity))
               plen = int'(dfr_capacity);
            if (pick < 50)
               kind = FK_GOOD;
            else if (pick < 70)
               kind = FK_CORRUPT;
            else if (pick < 76)
               kind = FK_APPERR;
            else if (pick < 81)
               kind = FK_EXTENDED;
            else if (pick < 84)
               kind = FK_SHORT;
            else if (pick < 90)
               kind = FK_TOOBIG;
            else
               kind = FK_NOISE;
            send_frame(kind, plen);
         end
      end

      drain_responses();
      repeat (4) @(posedge clock);
      $display("Sent %0d request bytes over %0d register settings, %0d frames closed.",
               sent_bytes, settings_used, frames_closed);
      $display("Mismatches: %0d", errors);
      if (errors == 0 && deframer_out_q.size() == 0)
         $display("nfc_normal_frame_receiver_core regression: pass");
      else
         $display("nfc_normal_frame_receiver_core regression: fail");
      $finish;
   end

endmodule

### nfc_normal_frame_receiver_core.f
rtl/core/nfcr_pkg.sv
rtl/core/nfc_normal_frame_receiver_core.sv
tb/tb.sv
